// File: rtl/tgh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgh_pkg
// Types, widths and helpers shared by the ground height query block.
// ----------------------------------------------------------------------------
package tgh_pkg;

  localparam int COORD_W = 32;
  localparam int OPND_W  = 34;              // multiplier operand, signed
  localparam int PROD_W  = 2 * OPND_W;      // multiplier product
  localparam int EDGE_W  = 67;              // edge function value
  localparam int AREA_W  = 69;              // sum of the edge values of a triangle
  localparam int NUM_W   = 102;             // interpolation numerator
  localparam int QUO_W   = 32;              // quotient bits

  localparam logic [1:0] REG_EYE_X = 2'd0;
  localparam logic [1:0] REG_EYE_Y = 2'd1;
  localparam logic [1:0] REG_EYE_Z = 2'd2;

  typedef struct packed {
    logic                      op;
    logic                      first;
    logic                      last;
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
    logic signed [COORD_W-1:0] c_x;
    logic signed [COORD_W-1:0] c_y;
    logic signed [COORD_W-1:0] c_z;
  } tgh_req_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] height;
    logic                      hit;
  } tgh_rsp_t;

  typedef struct packed {
    logic [1:0]         idx;
    logic [COORD_W-1:0] wdata;
  } tgh_cfg_t;

  function automatic logic signed [OPND_W-1:0] sx(input logic signed [COORD_W-1:0] v);
    sx = {{(OPND_W-COORD_W){v[COORD_W-1]}}, v};
  endfunction

endpackage
`default_nettype wire

// File: rtl/tgh_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgh_stream_if
// Valid/ready channel carrying one request or result payload.
// ----------------------------------------------------------------------------
interface tgh_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/tgh_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgh_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module tgh_mul (
  input  wire                                  clk,
  input  wire logic signed [tgh_pkg::OPND_W-1:0] a,
  input  wire logic signed [tgh_pkg::OPND_W-1:0] b,
  output logic signed [tgh_pkg::PROD_W-1:0]      p_r
);
  always_ff @(posedge clk) begin
    p_r <= a * b;
  end
endmodule
`default_nettype wire

// File: rtl/tgh_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tgh_div
// Restoring divider, one quotient bit per cycle. The caller guarantees
// the quotient fits in QUO_W bits.
// ----------------------------------------------------------------------------
module tgh_div (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   start,
  input  wire logic [tgh_pkg::NUM_W-1:0]        num,
  input  wire logic [tgh_pkg::AREA_W-1:0]       den,
  output logic                                  done_r,
  output logic [tgh_pkg::QUO_W-1:0]             quo_r
);
  localparam int NW = tgh_pkg::NUM_W;
  localparam int CW = $clog2(tgh_pkg::QUO_W);

  logic [NW-1:0] rem_r;
  logic [NW-1:0] dv_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r;
  logic          ge;
  logic [NW-1:0] dv_init;

  assign ge      = rem_r >= dv_r;
  assign dv_init = {{(NW-tgh_pkg::AREA_W-tgh_pkg::QUO_W+1){1'b0}}, den,
                    {(tgh_pkg::QUO_W-1){1'b0}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && busy_r && (cnt_r == '0);
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      dv_r  <= dv_init;
      cnt_r <= CW'(tgh_pkg::QUO_W - 1);
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - dv_r;
      end
      dv_r  <= dv_r >> 1;
      quo_r <= {quo_r[tgh_pkg::QUO_W-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without run");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !busy_r) else $error("divider restarted while busy");
  a_single_done: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("divider done held two cycles");
endmodule
`default_nettype wire

// File: rtl/triangle_ground_height_query_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// triangle_ground_height_query_core
// Ground height under a configured eye point, one triangle per request.
// ----------------------------------------------------------------------------
// Each request carries one triangle of a query. The block forms the edge
// functions of the eye in the x-z plane on one shared 34x34 multiplier (a
// pair of products per edge), checks coverage with a top-left rule on the z
// axis, builds the interpolation numerator on the same multiplier (a pair
// per vertex) and divides by the doubled area in a one-bit-per-cycle
// divider. The highest hit strictly below eye_y raises a running best that
// starts at 0 each query; the request marked last emits the held height and
// a hit flag. An empty query request (op set) emits height 0 with no hit. A
// covered triangle runs the multiplies, S_ACC, S_CHK, the divider and S_FIN
// before ready again; a missed triangle goes from S_CHK to S_FIN and an
// empty query request from idle to S_FIN. A request that emits a result
// also waits while the previous result is still unaccepted. Input ready is
// low while a request is in work. Configuration writes are always taken;
// they must only happen while idle.
// ----------------------------------------------------------------------------
module triangle_ground_height_query_core (
  input  wire        clk,
  input  wire        rst_n,
  tgh_stream_if.sink   in_req,
  tgh_stream_if.source out_rsp,
  tgh_stream_if.sink   cfg_wr
);
  localparam int CW = tgh_pkg::COORD_W;
  localparam int OW = tgh_pkg::OPND_W;
  localparam int PW = tgh_pkg::PROD_W;
  localparam int EW = tgh_pkg::EDGE_W;
  localparam int AW = tgh_pkg::AREA_W;
  localparam int NW = tgh_pkg::NUM_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ACC  = 3'd2;
  localparam logic [2:0] S_CHK  = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  localparam logic [3:0] LAST_STEP = 4'd11;

  // eye point
  logic signed [CW-1:0] eye_x_r, eye_y_r, eye_z_r;

  // query state
  logic signed [CW-1:0] best_r;
  logic signed [CW-1:0] held_r;
  logic                 qhit_r;

  // sequencer
  logic [2:0]           state_r;
  logic [3:0]           step_r;
  logic [3:0]           pstep_r;
  logic                 pvalid_r;
  tgh_pkg::tgh_req_t    item_r;
  logic                 tri_hit_r;

  // datapath
  logic signed [EW-1:0] w_r [3];
  logic [NW-1:0]        num_r;
  logic signed [OW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod_r;
  logic                 div_start, div_done;
  logic [CW-1:0]        quo;

  // result
  logic                 out_valid_r;
  tgh_pkg::tgh_rsp_t    out_data_r;

  // vertex views: 0 = a, 1 = b, 2 = c
  logic signed [CW-1:0] vx [3];
  logic signed [CW-1:0] vz [3];
  logic signed [CW-1:0] vy [3];
  logic signed [OW-1:0] dxp [3], dzt [3], dzp [3], dxt [3];
  logic [CW-1:0]        uy [3];

  assign vx[0] = item_r.a_x; assign vx[1] = item_r.b_x; assign vx[2] = item_r.c_x;
  assign vz[0] = item_r.a_z; assign vz[1] = item_r.b_z; assign vz[2] = item_r.c_z;
  assign vy[0] = item_r.a_y; assign vy[1] = item_r.b_y; assign vy[2] = item_r.c_y;

  // edge e runs from vertex (e+1)%3 to (e+2)%3: b->c, c->a, a->b
  for (genvar e = 0; e < 3; e++) begin : g_edge
    localparam int S = (e + 1) % 3;
    localparam int T = (e + 2) % 3;
    assign dxp[e] = tgh_pkg::sx(eye_x_r) - tgh_pkg::sx(vx[S]);
    assign dzp[e] = tgh_pkg::sx(eye_z_r) - tgh_pkg::sx(vz[S]);
    assign dxt[e] = tgh_pkg::sx(vx[T]) - tgh_pkg::sx(vx[S]);
    assign dzt[e] = tgh_pkg::sx(vz[T]) - tgh_pkg::sx(vz[S]);
    // heights offset to unsigned
    assign uy[e]  = vy[e] ^ {1'b1, {(CW-1){1'b0}}};
  end

  // operand select: edge products first, then numerator halves
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (step_r)
      4'd0:  begin mul_a = dxp[0]; mul_b = dzt[0]; end
      4'd1:  begin mul_a = dzp[0]; mul_b = dxt[0]; end
      4'd2:  begin mul_a = dxp[1]; mul_b = dzt[1]; end
      4'd3:  begin mul_a = dzp[1]; mul_b = dxt[1]; end
      4'd4:  begin mul_a = dxp[2]; mul_b = dzt[2]; end
      4'd5:  begin mul_a = dzp[2]; mul_b = dxt[2]; end
      4'd6:  begin mul_a = {1'b0, w_r[0][32:0]};  mul_b = {2'b00, uy[0]}; end
      4'd7:  begin mul_a = {1'b0, w_r[0][65:33]}; mul_b = {2'b00, uy[0]}; end
      4'd8:  begin mul_a = {1'b0, w_r[1][32:0]};  mul_b = {2'b00, uy[1]}; end
      4'd9:  begin mul_a = {1'b0, w_r[1][65:33]}; mul_b = {2'b00, uy[1]}; end
      4'd10: begin mul_a = {1'b0, w_r[2][32:0]};  mul_b = {2'b00, uy[2]}; end
      4'd11: begin mul_a = {1'b0, w_r[2][65:33]}; mul_b = {2'b00, uy[2]}; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
  end

  tgh_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod_r)
  );

  // coverage with top-left rule on z
  function automatic logic covers(input logic signed [EW-1:0] w,
                                  input logic signed [OW-1:0] ex,
                                  input logic signed [OW-1:0] ez);
    if (w[EW-1]) covers = 1'b0;
    else if (w != '0) covers = 1'b1;
    else covers = (ez > 0) || (ez == 0 && ex > 0);
  endfunction

  logic          all_cov;
  logic [AW-1:0] area;
  logic          tri_ok;

  assign all_cov = covers(w_r[0], dxt[0], dzt[0]) && covers(w_r[1], dxt[1], dzt[1]) &&
                   covers(w_r[2], dxt[2], dzt[2]);
  assign area    = AW'(w_r[0]) + AW'(w_r[1]) + AW'(w_r[2]);
  assign tri_ok  = all_cov && (area != '0);
  assign div_start = (state_r == S_CHK) && tri_ok;

  tgh_div u_div (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (div_start),
    .num    (num_r),
    .den    (area),
    .done_r (div_done),
    .quo_r  (quo)
  );

  // final update of the query state
  logic signed [CW-1:0] found;
  logic                 take;
  logic signed [CW-1:0] best_nxt;
  logic signed [CW-1:0] held_nxt;
  logic                 qhit_nxt;
  logic                 out_free;
  logic                 emit;

  assign found    = quo ^ {1'b1, {(CW-1){1'b0}}};
  assign take     = tri_hit_r && (found < eye_y_r);
  assign best_nxt = (take && found > best_r) ? found : best_r;
  assign held_nxt = take ? best_nxt : held_r;
  assign qhit_nxt = qhit_r || take;
  assign out_free = !out_valid_r || out_rsp.ready;
  assign emit     = (state_r == S_FIN) && (item_r.op || item_r.last) && out_free;

  assign in_req.ready  = (state_r == S_IDLE);
  assign cfg_wr.ready  = 1'b1;
  assign out_rsp.valid = out_valid_r;
  assign out_rsp.data  = out_data_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eye_x_r <= '0;
      eye_y_r <= '0;
      eye_z_r <= '0;
    end else if (cfg_wr.valid) begin
      case (cfg_wr.data.idx)
        tgh_pkg::REG_EYE_X: eye_x_r <= cfg_wr.data.wdata;
        tgh_pkg::REG_EYE_Y: eye_y_r <= cfg_wr.data.wdata;
        tgh_pkg::REG_EYE_Z: eye_z_r <= cfg_wr.data.wdata;
        default: ;
      endcase
    end
  end

  // sequencer and query state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      pvalid_r    <= 1'b0;
      tri_hit_r   <= 1'b0;
      best_r      <= '0;
      held_r      <= '0;
      qhit_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pvalid_r <= (state_r == S_MUL);
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_req.valid) begin
            if (in_req.data.op || in_req.data.first) begin
              best_r <= '0;
              qhit_r <= 1'b0;
            end
            tri_hit_r <= 1'b0;
            step_r    <= '0;
            state_r   <= in_req.data.op ? S_FIN : S_MUL;
          end
        end
        S_MUL: begin
          step_r <= step_r + 1'b1;
          if (step_r == LAST_STEP) state_r <= S_ACC;
        end
        S_ACC: state_r <= S_CHK;
        S_CHK: state_r <= tri_ok ? S_DIV : S_FIN;
        S_DIV: begin
          if (div_done) begin
            tri_hit_r <= 1'b1;
            state_r   <= S_FIN;
          end
        end
        S_FIN: begin
          if (item_r.op) begin
            if (out_free) state_r <= S_IDLE;
          end else if (!item_r.last) begin
            best_r  <= best_nxt;
            held_r  <= held_nxt;
            qhit_r  <= qhit_nxt;
            state_r <= S_IDLE;
          end else if (out_free) begin
            held_r  <= held_nxt;
            best_r  <= '0;
            qhit_r  <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) item_r <= in_req.data;
    pstep_r <= step_r;
    if (emit) begin
      out_data_r.height <= item_r.op ? '0 : held_nxt;
      out_data_r.hit    <= item_r.op ? 1'b0 : qhit_nxt;
    end
    // accumulate the product issued in the previous cycle
    if (pvalid_r) begin
      case (pstep_r)
        4'd0:  w_r[0] <= prod_r[EW-1:0];
        4'd1:  w_r[0] <= w_r[0] - prod_r[EW-1:0];
        4'd2:  w_r[1] <= prod_r[EW-1:0];
        4'd3:  w_r[1] <= w_r[1] - prod_r[EW-1:0];
        4'd4:  w_r[2] <= prod_r[EW-1:0];
        4'd5:  w_r[2] <= w_r[2] - prod_r[EW-1:0];
        4'd6:  num_r  <= NW'(prod_r[65:0]);
        4'd7, 4'd9, 4'd11:
               num_r  <= num_r + NW'({prod_r[65:0], 33'b0});
        4'd8, 4'd10:
               num_r  <= num_r + NW'(prod_r[65:0]);
        default: ;
      endcase
    end
  end

  a_emit_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result raised outside final state");
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) && $past(item_r.op) |-> out_data_r.height == '0 && !out_data_r.hit)
    else $error("empty query gave nonzero result");
  a_div_in_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_DIV) else $error("divider finished out of sequence");
  a_hit_held: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) && out_data_r.hit |-> out_data_r.height == held_r)
    else $error("hit result differs from held height");
endmodule
`default_nettype wire
